[sv/gsp_pkg.sv]
`default_nettype none

package gsp_pkg;

    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;
    localparam int DZ_W   = 15;
    localparam int POS_W  = 4;

    localparam logic [2:0] OP_STROBE = 3'd0;
    localparam logic [2:0] OP_READ   = 3'd1;
    localparam logic [2:0] OP_SET    = 3'd2;
    localparam logic [2:0] OP_AXIS   = 3'd3;
    localparam logic [2:0] OP_HAT    = 3'd4;
    localparam logic [2:0] OP_JOY    = 3'd5;

    localparam logic [2:0] BTN_A      = 3'd0;
    localparam logic [2:0] BTN_B      = 3'd1;
    localparam logic [2:0] BTN_SELECT = 3'd2;
    localparam logic [2:0] BTN_START  = 3'd3;
    localparam logic [2:0] BTN_UP     = 3'd4;
    localparam logic [2:0] BTN_DOWN   = 3'd5;
    localparam logic [2:0] BTN_LEFT   = 3'd6;
    localparam logic [2:0] BTN_RIGHT  = 3'd7;

    localparam logic [1:0] REG_DEADZONE = 2'd0;
    localparam logic [1:0] REG_PAD1_MAP = 2'd1;
    localparam logic [1:0] REG_PAD2_MAP = 2'd2;

    localparam logic [DZ_W-1:0]   DEADZONE_RST = 15'd8000;
    localparam logic [DATA_W-1:0] MAP_RST      = 32'h0908_0001;

    localparam logic [7:0] RD_PRESSED  = 8'h41;
    localparam logic [7:0] RD_RELEASED = 8'h40;
    localparam logic [7:0] RD_DONE     = 8'h01;
    localparam logic [POS_W-1:0] POS_END = 4'd8;

    localparam logic [7:0] JOY_FIX_B0      = 8'd0;
    localparam logic [7:0] JOY_FIX_A0      = 8'd1;
    localparam logic [7:0] JOY_FIX_A1      = 8'd4;
    localparam logic [7:0] JOY_FIX_B1      = 8'd5;
    localparam logic [7:0] JOY_FIX_SELECT  = 8'd8;
    localparam logic [7:0] JOY_FIX_START   = 8'd9;

    typedef struct packed {
        logic [2:0]         opcode;
        logic               player;
        logic [7:0]         data;
        logic [2:0]         button;
        logic               pressed;
        logic               axis;
        logic signed [15:0] axis_value;
    } item_t;

    typedef struct packed {
        logic [DZ_W-1:0]   deadzone;
        logic [DATA_W-1:0] pad1_map;
        logic [DATA_W-1:0] pad2_map;
    } cfg_t;

endpackage

`default_nettype wire

[sv/gsp_cfg_regs.sv]
`default_nettype none

module gsp_cfg_regs (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [gsp_pkg::ADDR_W-1:0]  paddr,
    input  wire logic [gsp_pkg::DATA_W-1:0]  pwdata,
    output logic      [gsp_pkg::DATA_W-1:0]  prdata,
    output logic                             pready,
    output gsp_pkg::cfg_t                    cfg
);
    import gsp_pkg::*;

    logic [DZ_W-1:0]   deadzone_reg;
    logic [DATA_W-1:0] pad1_map_reg;
    logic [DATA_W-1:0] pad2_map_reg;
    logic [1:0]        reg_index;
    logic              wr_en;

    assign reg_index = paddr[3:2];
    assign wr_en     = psel && penable && pwrite;
    assign pready    = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            deadzone_reg <= DEADZONE_RST;
            pad1_map_reg <= MAP_RST;
            pad2_map_reg <= MAP_RST;
        end
        else if (wr_en)
        begin
            case (reg_index)
                REG_DEADZONE: deadzone_reg <= pwdata[DZ_W-1:0];
                REG_PAD1_MAP: pad1_map_reg <= pwdata;
                REG_PAD2_MAP: pad2_map_reg <= pwdata;
                default:      ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_index)
            REG_DEADZONE: prdata = {{(DATA_W-DZ_W){1'b0}}, deadzone_reg};
            REG_PAD1_MAP: prdata = pad1_map_reg;
            REG_PAD2_MAP: prdata = pad2_map_reg;
            default:      prdata = '0;
        endcase
    end

    assign cfg.deadzone = deadzone_reg;
    assign cfg.pad1_map = pad1_map_reg;
    assign cfg.pad2_map = pad2_map_reg;

endmodule

`default_nettype wire

[sv/gsp_in_stage.sv]
`default_nettype none

module gsp_in_stage (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           take,
    input  wire logic           advance,
    input  wire gsp_pkg::item_t item_in,
    output logic                item_valid,
    output gsp_pkg::item_t      item_out
);
    import gsp_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (take)
            valid_next = 1'b1;
        else if (advance)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (take)
            item_reg <= item_in;
    end

    assign item_valid = valid_reg;
    assign item_out   = item_reg;

endmodule

`default_nettype wire

[sv/gsp_pad_core.sv]
`default_nettype none

module gsp_pad_core (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           advance,
    input  wire logic           out_stall,
    input  wire gsp_pkg::item_t item,
    input  wire gsp_pkg::cfg_t  cfg,
    output logic                out_valid,
    output logic [7:0]          read_data
);
    import gsp_pkg::*;

    logic              strobe_reg;
    logic              strobe_next;
    logic [POS_W-1:0]  pos_reg   [2];
    logic [POS_W-1:0]  pos_next  [2];
    logic [7:0]        bits_reg  [2];
    logic [7:0]        bits_next [2];
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [7:0]        read_data_reg;
    logic [7:0]        read_data_next;

    logic [POS_W-1:0]  pos_cur;
    logic [7:0]        bits_cur;
    logic [7:0]        bits_new;
    logic [DATA_W-1:0] map_cur;
    logic signed [16:0] val_ext;
    logic signed [16:0] dz_ext;
    logic [2:0]        neg_btn;
    logic [2:0]        pos_btn;

    assign pos_cur  = pos_reg[item.player];
    assign bits_cur = bits_reg[item.player];
    assign map_cur  = item.player ? cfg.pad2_map : cfg.pad1_map;
    assign val_ext  = {item.axis_value[15], item.axis_value};
    assign dz_ext   = {2'b00, cfg.deadzone};
    assign neg_btn  = item.axis ? BTN_UP : BTN_LEFT;
    assign pos_btn  = item.axis ? BTN_DOWN : BTN_RIGHT;

    always_comb
    begin
        strobe_next    = strobe_reg;
        pos_next       = pos_reg;
        bits_next      = bits_reg;
        bits_new       = bits_cur;
        read_data_next = 8'h00;

        case (item.opcode)
            OP_STROBE:
            begin
                if (!item.data[0] && strobe_reg)
                begin
                    pos_next[0] = '0;
                    pos_next[1] = '0;
                end
                strobe_next = item.data[0];
            end
            OP_READ:
            begin
                if (!pos_cur[3])
                begin
                    read_data_next = bits_cur[pos_cur[2:0]] ? RD_PRESSED : RD_RELEASED;
                    if (!strobe_reg)
                        pos_next[item.player] = pos_cur + POS_W'(1);
                end
                else
                    read_data_next = RD_DONE;
            end
            OP_SET:
                bits_new[item.button] = item.pressed;
            OP_AXIS:
            begin
                if (val_ext < -dz_ext)
                begin
                    bits_new[neg_btn] = 1'b1;
                    bits_new[pos_btn] = 1'b0;
                end
                else if (val_ext > dz_ext)
                begin
                    bits_new[pos_btn] = 1'b1;
                    bits_new[neg_btn] = 1'b0;
                end
                else
                begin
                    bits_new[neg_btn] = 1'b0;
                    bits_new[pos_btn] = 1'b0;
                end
            end
            OP_HAT:
            begin
                bits_new[BTN_UP]    = item.data[0];
                bits_new[BTN_DOWN]  = item.data[2];
                bits_new[BTN_LEFT]  = item.data[3];
                bits_new[BTN_RIGHT] = item.data[1];
            end
            OP_JOY:
            begin
                priority if (item.data == map_cur[7:0])
                    bits_new[BTN_A] = item.pressed;
                else if (item.data == map_cur[15:8])
                    bits_new[BTN_B] = item.pressed;
                else if (item.data == map_cur[23:16])
                    bits_new[BTN_START] = item.pressed;
                else if (item.data == map_cur[31:24])
                    bits_new[BTN_SELECT] = item.pressed;
                else
                    ;
                case (item.data)
                    JOY_FIX_B0, JOY_FIX_B1: bits_new[BTN_B]      = item.pressed;
                    JOY_FIX_A0, JOY_FIX_A1: bits_new[BTN_A]      = item.pressed;
                    JOY_FIX_SELECT:         bits_new[BTN_SELECT] = item.pressed;
                    JOY_FIX_START:          bits_new[BTN_START]  = item.pressed;
                    default:                ;
                endcase
            end
            default: ;
        endcase

        bits_next[item.player] = bits_new;
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strobe_reg    <= 1'b1;
            pos_reg[0]    <= '0;
            pos_reg[1]    <= '0;
            bits_reg[0]   <= '0;
            bits_reg[1]   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (advance)
            begin
                strobe_reg <= strobe_next;
                pos_reg    <= pos_next;
                bits_reg   <= bits_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            read_data_reg <= read_data_next;
    end

    assign out_valid = out_valid_reg;
    assign read_data = read_data_reg;

    a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg[0] <= POS_END && pos_reg[1] <= POS_END)
        else $error("read position past end");

    a_nonread_zero: assert property (@(posedge clk) disable iff (!rst_n)
        advance && item.opcode != OP_READ |=> read_data_reg == 8'h00)
        else $error("non-read transfer returned data");

    a_strobe_rewind: assert property (@(posedge clk) disable iff (!rst_n)
        advance && item.opcode == OP_STROBE && !item.data[0] && strobe_reg
        |=> pos_reg[0] == '0 && pos_reg[1] == '0)
        else $error("strobe fall did not rewind");

    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_stall |-> !advance)
        else $error("result overwritten while stalled");

endmodule

`default_nettype wire

[sv/gamepad_serial_port_unit.sv]
// Two-player game-pad port.
// Input channel: in_valid/in_stall with opcode, player, data, button,
// pressed, axis, axis_value; a transfer happens on a clock edge with
// in_valid high and in_stall low. Every input transfer yields exactly one
// output transfer on out_valid/out_stall carrying read_data (the port byte
// for a read, zero otherwise).
// An item taken into the input register moves on into the result register,
// which then raises out_valid.
// Throughput: one item per cycle unless stalled; input and result registers
// form a two-entry pipeline updating button, strobe and position state in order.
// When the receiver stalls, the result holds; the input register still
// takes one more item, then in_stall rises until the result is taken.
// Configuration: APB port, deadzone at 0x0, pad maps at 0x4 and 0x8, one
// write per setup/access pair, pready always high; write only when idle.
// Reset (rst_n low, asynchronous): both pipeline stages empty, strobe high,
// positions zero, all buttons released, registers at defaults.
`default_nettype none

module gamepad_serial_port_unit (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_stall,
    input  wire logic [2:0]                  opcode,
    input  wire logic                        player,
    input  wire logic [7:0]                  data,
    input  wire logic [2:0]                  button,
    input  wire logic                        pressed,
    input  wire logic                        axis,
    input  wire logic signed [15:0]          axis_value,
    output logic                             out_valid,
    input  wire logic                        out_stall,
    output logic [7:0]                       read_data,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [gsp_pkg::ADDR_W-1:0]  paddr,
    input  wire logic [gsp_pkg::DATA_W-1:0]  pwdata,
    output logic      [gsp_pkg::DATA_W-1:0]  prdata,
    output logic                             pready
);
    import gsp_pkg::*;

    item_t item_in;
    item_t item_q;
    cfg_t  cfg;
    logic  item_valid;
    logic  out_free;
    logic  advance;
    logic  take;

    assign item_in.opcode     = opcode;
    assign item_in.player     = player;
    assign item_in.data       = data;
    assign item_in.button     = button;
    assign item_in.pressed    = pressed;
    assign item_in.axis       = axis;
    assign item_in.axis_value = axis_value;

    assign out_free = !out_valid || !out_stall;
    assign advance  = item_valid && out_free;
    assign in_stall = item_valid && !out_free;
    assign take     = in_valid && !in_stall;

    gsp_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    gsp_in_stage u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .take       (take),
        .advance    (advance),
        .item_in    (item_in),
        .item_valid (item_valid),
        .item_out   (item_q)
    );

    gsp_pad_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .out_stall (out_stall),
        .item      (item_q),
        .cfg       (cfg),
        .out_valid (out_valid),
        .read_data (read_data)
    );

endmodule

`default_nettype wire

[tb/gamepad_serial_port_checker.sv]
module gamepad_serial_port_checker
    import gsp_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_stall,
    input  logic [2:0]          opcode,
    input  logic                player,
    input  logic [7:0]          data,
    input  logic [2:0]          button,
    input  logic                pressed,
    input  logic                axis,
    input  logic signed [15:0]  axis_value,
    input  logic                out_valid,
    input  logic                out_stall,
    input  logic [7:0]          read_data,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [ADDR_W-1:0]   paddr,
    input  logic [DATA_W-1:0]   pwdata,
    input  logic [DATA_W-1:0]   prdata,
    input  logic                pready,
    output int                  mismatch_count,
    output int                  bytes_outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [DZ_W-1:0]   deadzone;
    logic [DATA_W-1:0] pad_map [2];
    logic              strobe_hi;
    logic [POS_W-1:0]  scan_pos [2];
    logic [7:0]        pad_bits [2];
    logic [7:0]        port_bytes_due [$];
    int                fail_total = 0;

    assign mismatch_count = fail_total;

    task automatic report_miss(string what, logic [DATA_W-1:0] expected,
                               logic [DATA_W-1:0] actual);
        fail_total++;
        if (fail_total <= 10)
            $display("%0t: %s: expected %0h, got %0h", $time, what, expected, actual);
    endtask

    // Applies one input transfer to the pad state; returns the byte it produces.
    function automatic logic [7:0] port_byte_for(item_t it);
        logic [7:0]        rd_byte;
        logic [POS_W-1:0]  pos;
        logic [DATA_W-1:0] map;
        logic [2:0]        neg_btn;
        logic [2:0]        pos_btn;
        int                val;
        int                dz;
        rd_byte = 8'h00;
        pos     = scan_pos[it.player];
        case (it.opcode)
            OP_STROBE:
            begin
                if (!it.data[0] && strobe_hi)
                begin
                    scan_pos[0] = '0;
                    scan_pos[1] = '0;
                end
                strobe_hi = it.data[0];
            end
            OP_READ:
            begin
                if (pos < POS_END)
                begin
                    rd_byte = pad_bits[it.player][pos[2:0]] ? RD_PRESSED : RD_RELEASED;
                    if (!strobe_hi)
                        scan_pos[it.player] = pos + 1'b1;
                end
                else
                    rd_byte = RD_DONE;
            end
            OP_SET:
                pad_bits[it.player][it.button] = it.pressed;
            OP_AXIS:
            begin
                val     = $signed(it.axis_value);
                dz      = int'(deadzone);
                neg_btn = it.axis ? BTN_UP : BTN_LEFT;
                pos_btn = it.axis ? BTN_DOWN : BTN_RIGHT;
                pad_bits[it.player][neg_btn] = (val < -dz);
                pad_bits[it.player][pos_btn] = (val > dz);
            end
            OP_HAT:
            begin
                pad_bits[it.player][BTN_UP]    = it.data[0];
                pad_bits[it.player][BTN_RIGHT] = it.data[1];
                pad_bits[it.player][BTN_DOWN]  = it.data[2];
                pad_bits[it.player][BTN_LEFT]  = it.data[3];
            end
            OP_JOY:
            begin
                map = pad_map[it.player];
                // first matching map byte wins, then the fixed numbers apply on top
                if (it.data == map[7:0])
                    pad_bits[it.player][BTN_A] = it.pressed;
                else if (it.data == map[15:8])
                    pad_bits[it.player][BTN_B] = it.pressed;
                else if (it.data == map[23:16])
                    pad_bits[it.player][BTN_START] = it.pressed;
                else if (it.data == map[31:24])
                    pad_bits[it.player][BTN_SELECT] = it.pressed;
                case (it.data)
                    JOY_FIX_B0, JOY_FIX_B1:
                        pad_bits[it.player][BTN_B] = it.pressed;
                    JOY_FIX_A0, JOY_FIX_A1:
                        pad_bits[it.player][BTN_A] = it.pressed;
                    JOY_FIX_SELECT:
                        pad_bits[it.player][BTN_SELECT] = it.pressed;
                    JOY_FIX_START:
                        pad_bits[it.player][BTN_START] = it.pressed;
                    default: ;
                endcase
            end
            default: ;
        endcase
        return rd_byte;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        logic [DATA_W-1:0] reg_expect;
        logic [7:0]        byte_expect;
        if (!rst_n)
        begin
            deadzone    = DEADZONE_RST;
            pad_map[0]  = MAP_RST;
            pad_map[1]  = MAP_RST;
            strobe_hi   = 1'b1;
            scan_pos[0] = '0;
            scan_pos[1] = '0;
            pad_bits[0] = '0;
            pad_bits[1] = '0;
            port_bytes_due.delete();
            bytes_outstanding <= 0;
        end
        else
        begin
            if (psel && penable && pready)
            begin
                if (pwrite)
                begin
                    case (paddr[3:2])
                        REG_DEADZONE: deadzone   = pwdata[DZ_W-1:0];
                        REG_PAD1_MAP: pad_map[0] = pwdata;
                        REG_PAD2_MAP: pad_map[1] = pwdata;
                        default: ;
                    endcase
                end
                else if (paddr[3:2] != 2'(3))
                begin
                    case (paddr[3:2])
                        REG_DEADZONE: reg_expect = DATA_W'(deadzone);
                        REG_PAD1_MAP: reg_expect = pad_map[0];
                        default:      reg_expect = pad_map[1];
                    endcase
                    if (prdata !== reg_expect)
                        report_miss("register readback", reg_expect, prdata);
                end
            end
            if (out_valid && !out_stall)
            begin
                if (port_bytes_due.size() == 0)
                    report_miss("result transfer with none pending", 'x, read_data);
                else
                begin
                    byte_expect = port_bytes_due.pop_front();
                    if (read_data !== byte_expect)
                        report_miss("read_data", byte_expect, read_data);
                end
            end
            if (in_valid && !in_stall)
                port_bytes_due.push_back(port_byte_for(item_t'{opcode, player, data, button,
                                                                pressed, axis, axis_value}));
            bytes_outstanding <= port_bytes_due.size();
        end
    end

endmodule

[tb/tb_gamepad_serial_port_unit.sv]
module tb_gamepad_serial_port_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import gsp_pkg::*;

    localparam logic [1:0] REG_UNUSED  = 2'd3;
    localparam logic [2:0] OP_SPARE_LO = 3'd6;
    localparam logic [2:0] OP_SPARE_HI = 3'd7;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              in_valid;
    logic              in_stall;
    item_t             stim;
    logic              out_valid;
    logic              out_stall;
    logic [7:0]        read_data;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;
    int                mismatch_count;
    int                bytes_outstanding;

    int                items_sent    = 0;
    int                results_taken = 0;
    bit                tx_busy;
    bit                rx_busy;
    int                cur_dz;
    logic [DATA_W-1:0] cur_map [2];

    always #1 clk = ~clk;

    gamepad_serial_port_unit dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .opcode     (stim.opcode),
        .player     (stim.player),
        .data       (stim.data),
        .button     (stim.button),
        .pressed    (stim.pressed),
        .axis       (stim.axis),
        .axis_value (stim.axis_value),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .read_data  (read_data),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    gamepad_serial_port_checker chk (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .opcode            (stim.opcode),
        .player            (stim.player),
        .data              (stim.data),
        .button            (stim.button),
        .pressed           (stim.pressed),
        .axis              (stim.axis),
        .axis_value        (stim.axis_value),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .read_data         (read_data),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready),
        .mismatch_count    (mismatch_count),
        .bytes_outstanding (bytes_outstanding)
    );

    function automatic item_t mk(logic [2:0] op, logic pl, logic [7:0] dat, logic [2:0] btn,
                                 logic prs, logic ax, int val);
        item_t it;
        it.opcode     = op;
        it.player     = pl;
        it.data       = dat;
        it.button     = btn;
        it.pressed    = prs;
        it.axis       = ax;
        it.axis_value = 16'(val);
        return it;
    endfunction

    function automatic logic [DATA_W-1:0] map_value();
        logic [DATA_W-1:0] map;
        for (int i = 0; i < 4; i++)
            map[8*i +: 8] = $urandom_range(0, 1) ? 8'($urandom_range(0, 12)) : 8'($urandom);
        return map;
    endfunction

    // Random transfer; events_only keeps it to button-changing operations.
    function automatic item_t rand_item(bit events_only);
        item_t       it;
        logic [63:0] noise;
        int          pick;
        int          val;
        noise = {$urandom, $urandom};
        it    = noise[$bits(item_t)-1:0];
        pick  = events_only ? $urandom_range(9, 18) : $urandom_range(0, 19);
        if (pick <= 2)
            it.opcode = OP_STROBE;
        else if (pick <= 8)
            it.opcode = OP_READ;
        else if (pick <= 11)
            it.opcode = OP_SET;
        else if (pick <= 14)
            it.opcode = OP_AXIS;
        else if (pick <= 16)
            it.opcode = OP_HAT;
        else if (pick <= 18)
            it.opcode = OP_JOY;
        else
            it.opcode = $urandom_range(0, 1) ? OP_SPARE_LO : OP_SPARE_HI;
        if (it.opcode == OP_AXIS)
        begin
            case ($urandom_range(0, 3))
                1:
                begin
                    // right at the deadzone edge
                    val = cur_dz - 1 + int'($urandom_range(0, 2));
                    if ($urandom_range(0, 1))
                        val = -val;
                    it.axis_value = 16'(val);
                end
                2: it.axis_value = $urandom_range(0, 1) ? 16'sh8000 : 16'sh7fff;
                3: it.axis_value = 16'(int'($urandom_range(0, 600)) - 300);
                default: ;
            endcase
        end
        if (it.opcode == OP_JOY)
        begin
            case ($urandom_range(0, 2))
                0: it.data = 8'($urandom_range(0, 12));
                1: it.data = 8'(cur_map[it.player] >> (8 * $urandom_range(0, 3)));
                default: ;
            endcase
        end
        return it;
    endfunction

    task automatic send(item_t it);
        int gap;
        if (items_sent % 40 == 0)
            tx_busy = $urandom_range(0, 1);
        gap = tx_busy ? $urandom_range(0, 16) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        stim     <= it;
        do
            @(posedge clk);
        while (in_stall);
        items_sent++;
    endtask

    // Strobe high, strobe low, then a burst of reads mostly from one pad, with some button events mixed in.
    task automatic run_scan();
        item_t it;
        int    n;
        logic  focus;
        focus = $urandom_range(0, 1);
        it = rand_item(1'b0);
        it.opcode  = OP_STROBE;
        it.data[0] = 1'b1;
        send(it);
        it.data    = $urandom;
        it.data[0] = 1'b0;
        send(it);
        n = $urandom_range(6, 12);
        repeat (n)
        begin
            if ($urandom_range(0, 3) == 0)
                send(rand_item(1'b1));
            it = rand_item(1'b0);
            it.opcode = OP_READ;
            it.player = ($urandom_range(0, 4) == 0) ? ~focus : focus;
            send(it);
        end
    endtask

    task automatic apb_access(logic wr, logic [1:0] idx, logic [DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_config(logic [DZ_W-1:0] dz, logic [DATA_W-1:0] m1,
                              logic [DATA_W-1:0] m2);
        logic [DATA_W-1:0] dz_word;
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (bytes_outstanding != 0);
        dz_word = $urandom;
        dz_word[DZ_W-1:0] = dz;
        apb_access(1'b1, REG_DEADZONE, dz_word);
        apb_access(1'b1, REG_PAD1_MAP, m1);
        apb_access(1'b1, REG_PAD2_MAP, m2);
        apb_access(1'b1, REG_UNUSED, $urandom);
        apb_access(1'b0, REG_DEADZONE, '0);
        apb_access(1'b0, REG_PAD1_MAP, '0);
        apb_access(1'b0, REG_PAD2_MAP, '0);
        cur_dz     = int'(dz);
        cur_map[0] = m1;
        cur_map[1] = m2;
    endtask

    initial
    begin
        #1_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        int hold;
        out_stall <= 1'b0;
        @(posedge clk);
        forever
        begin
            if (results_taken % 32 == 0)
                rx_busy = $urandom_range(0, 1);
            hold = rx_busy ? $urandom_range(0, 16) : 0;
            if (hold > 0)
            begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
                out_stall <= 1'b0;
            end
            do
                @(posedge clk);
            while (!out_valid);
            results_taken++;
        end
    end

    initial
    begin
        int phase_end;
        rst_n    <= 1'b0;
        in_valid <= 1'b0;
        stim     <= '0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        cur_dz     = int'(DEADZONE_RST);
        cur_map[0] = MAP_RST;
        cur_map[1] = MAP_RST;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // strobe is high out of reset, so reads sit on button A
        send(mk(OP_READ, 1'b0, 8'h00, BTN_A, 1'b0, 1'b0, 0));
        send(mk(OP_READ, 1'b1, 8'hff, BTN_A, 1'b0, 1'b0, 0));
        send(mk(OP_SET, 1'b0, 8'h00, BTN_A, 1'b1, 1'b0, 0));
        send(mk(OP_SET, 1'b1, 8'h00, BTN_RIGHT, 1'b1, 1'b1, 0));
        send(mk(OP_READ, 1'b0, 8'h00, BTN_A, 1'b0, 1'b0, 0));
        // falling strobe with junk in the upper bits rewinds both pads
        send(mk(OP_STROBE, 1'b1, 8'hfe, BTN_RIGHT, 1'b1, 1'b1, -1));
        repeat (9) send(mk(OP_READ, 1'b0, 8'h00, BTN_A, 1'b0, 1'b0, 0));
        send(mk(OP_STROBE, 1'b0, 8'h01, BTN_A, 1'b0, 1'b0, 0));
        send(mk(OP_READ, 1'b1, 8'h00, BTN_A, 1'b0, 1'b0, 0));
        send(mk(OP_READ, 1'b0, 8'h00, BTN_A, 1'b0, 1'b0, 0));
        send(mk(OP_AXIS, 1'b0, 8'h00, BTN_A, 1'b0, 1'b0, -32768));
        send(mk(OP_AXIS, 1'b1, 8'h00, BTN_A, 1'b0, 1'b1, 32767));
        send(mk(OP_AXIS, 1'b1, 8'h00, BTN_A, 1'b0, 1'b0, 8000));
        send(mk(OP_HAT, 1'b1, 8'hff, BTN_A, 1'b0, 1'b0, 0));
        send(mk(OP_JOY, 1'b0, 8'h00, BTN_A, 1'b1, 1'b0, 0));
        send(mk(OP_JOY, 1'b1, 8'h08, BTN_A, 1'b1, 1'b0, 0));
        send(mk(OP_SPARE_LO, 1'b0, 8'hff, BTN_RIGHT, 1'b1, 1'b1, -1));
        send(mk(OP_SPARE_HI, 1'b1, 8'hff, BTN_RIGHT, 1'b1, 1'b1, -1));

        for (int ph = 0; ph < 7; ph++)
        begin
            case (ph)
                0: ;
                1: set_config('0, '1, '1);
                2: set_config('1, '0, '0);
                default: set_config(DZ_W'($urandom_range(0, 32767)), map_value(), map_value());
            endcase
            phase_end = items_sent + 185;
            while (items_sent < phase_end)
            begin
                if ($urandom_range(0, 2) != 0)
                    run_scan();
                else
                    repeat (4) send(rand_item(1'b0));
            end
        end

        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (bytes_outstanding != 0);
        repeat (8) @(posedge clk);
        if (mismatch_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
